// ===== src/tsfb_pkg.sv =====
// Shared types and constants for the TCP SYN frame builder.
// No dependencies; every other file imports this package.
package tsfb_pkg;

    localparam int FRAME_BYTES = 62;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 48;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_MAC   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_MAC     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_IP    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_IP      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_PORT  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TIME_TO_LIVE = 3'd5;

    localparam logic [15:0] SOURCE_PORT_RST = 16'd61000;
    localparam logic [7:0]  TTL_RST         = 8'd64;

    localparam logic [7:0]  IP_PROTO_TCP  = 8'h06;
    localparam logic [15:0] IP_TOTAL_LEN  = 16'(FRAME_BYTES - 14);
    localparam logic [15:0] TCP_LEN       = 16'd28;
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [31:0] TCP_SEQ       = 32'hB747_4CCC;
    localparam logic [15:0] TCP_WINDOW    = 16'h4000;

    // fixed IPv4 header words: version/IHL, total length, flags
    localparam int IP_CONST_RAW = 'h4500 + int'(IP_TOTAL_LEN) + 'h4000;
    // fixed TCP words plus pseudo-header protocol and length
    localparam int TCP_CONST_RAW = int'(TCP_SEQ[31:16]) + int'(TCP_SEQ[15:0])
        + 'h7002 + int'(TCP_WINDOW) + 'h0204 + 'h05B4 + 'h0101 + 'h0402
        + int'(IP_PROTO_TCP) + int'(TCP_LEN);
    localparam int IP_CONST_F1  = (IP_CONST_RAW & 'hFFFF) + (IP_CONST_RAW >> 16);
    localparam int TCP_CONST_F1 = (TCP_CONST_RAW & 'hFFFF) + (TCP_CONST_RAW >> 16);
    localparam logic [15:0] IP_CONST  = 16'((IP_CONST_F1 & 'hFFFF) + (IP_CONST_F1 >> 16));
    localparam logic [15:0] TCP_CONST = 16'((TCP_CONST_F1 & 'hFFFF) + (TCP_CONST_F1 >> 16));

    typedef struct packed {
        logic [15:0] dest_port;
        logic [15:0] ip_ident;
    } in_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } out_item_t;

    typedef struct packed {
        logic [47:0] source_mac;
        logic [47:0] dest_mac;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [7:0]  time_to_live;
    } cfg_t;

    // one classified probe waiting for the emitter
    typedef struct packed {
        logic [15:0] dest_port;
        logic [15:0] ip_ident;
        logic [15:0] ip_csum;
        logic [15:0] tcp_csum;
    } probe_t;

endpackage

// ===== src/tsfb_front.sv =====
// Front end: accepts items, computes IPv4 and TCP checksums over a short pipeline.
// Depends on tsfb_pkg; feeds tsfb_queue and takes credit back from its pops.
module tsfb_front
    import tsfb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     item_valid,
    output logic     item_stall,
    input  in_item_t item,
    input  logic     pop,
    output logic     push,
    output probe_t   push_entry,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] credit
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0] credit_reg, credit_next;
    logic          accept;

    logic          v1_reg, v2_reg, v3_reg, v4_reg;
    in_item_t      it1_reg, it2_reg, it3_reg;
    logic [17:0]   addr_sum2_reg, ipb2_reg, tcpb2_reg;
    logic [18:0]   ip_sum3_reg, tcp_sum3_reg;
    probe_t        ent4_reg, ent4_next;

    logic [16:0]   ip_f1, tcp_f1;
    logic [15:0]   ip_f2, tcp_f2;

    // credit counts items in flight plus items queued, so the queue never overflows
    assign item_stall = (credit_reg == CW'(QUEUE_DEPTH));
    assign accept     = item_valid && !item_stall;
    assign credit     = credit_reg;

    always_comb
    begin
        credit_next = credit_reg;
        if (accept && !pop)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (!accept && pop)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    // end-around carry fold, then complement
    always_comb
    begin
        ip_f1  = 17'(ip_sum3_reg[15:0]) + 17'(ip_sum3_reg[18:16]);
        tcp_f1 = 17'(tcp_sum3_reg[15:0]) + 17'(tcp_sum3_reg[18:16]);
        ip_f2  = ip_f1[15:0] + 16'(ip_f1[16]);
        tcp_f2 = tcp_f1[15:0] + 16'(tcp_f1[16]);
        ent4_next.dest_port = it3_reg.dest_port;
        ent4_next.ip_ident  = it3_reg.ip_ident;
        ent4_next.ip_csum   = ~ip_f2;
        ent4_next.tcp_csum  = ~tcp_f2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            v4_reg     <= 1'b0;
        end
        else
        begin
            credit_reg <= credit_next;
            v1_reg     <= accept;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            v4_reg     <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            it1_reg <= item;
        end
        it2_reg       <= it1_reg;
        // source and destination address words appear in both sums
        addr_sum2_reg <= 18'(cfg.source_ip[31:16]) + 18'(cfg.source_ip[15:0])
                       + 18'(cfg.dest_ip[31:16]) + 18'(cfg.dest_ip[15:0]);
        ipb2_reg      <= 18'({cfg.time_to_live, IP_PROTO_TCP}) + 18'(it1_reg.ip_ident)
                       + 18'(IP_CONST);
        tcpb2_reg     <= 18'(cfg.source_port) + 18'(it1_reg.dest_port) + 18'(TCP_CONST);
        it3_reg       <= it2_reg;
        ip_sum3_reg   <= 19'(addr_sum2_reg) + 19'(ipb2_reg);
        tcp_sum3_reg  <= 19'(addr_sum2_reg) + 19'(tcpb2_reg);
        ent4_reg      <= ent4_next;
    end

    assign push       = v4_reg;
    assign push_entry = ent4_reg;

endmodule

// ===== src/tsfb_queue.sv =====
// Small FIFO of classified probes between front end and emitter.
// Depends on tsfb_pkg for the entry type.
module tsfb_queue
    import tsfb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  probe_t push_entry,
    input  logic   pop,
    output logic   head_valid,
    output probe_t head_entry,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    probe_t        mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    probe_t        head_reg;
    logic          bypass;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        if (p == PW'(QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        if (pop)
        begin
            rd_ptr_next = wrap_inc(rd_ptr_reg);
        end
    end

    // head is prefetched; an item pushed into an empty queue goes straight to it
    assign bypass = push && (count_next == CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
            if (push)
            begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
        if (bypass)
        begin
            head_reg <= push_entry;
        end
        else
        begin
            head_reg <= mem_reg[rd_ptr_next];
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_entry = head_reg;
    assign count      = count_reg;

endmodule

// ===== src/tsfb_back.sv =====
// Emitter: walks one probe through the 62 frame bytes into an output register.
// Depends on tsfb_pkg; pops probes from tsfb_queue.
module tsfb_back
    import tsfb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      head_valid,
    input  probe_t    head_entry,
    output logic      pop,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    localparam logic [5:0] LAST_POS = 6'(FRAME_BYTES - 1);

    logic       active_reg, active_next;
    logic [5:0] pos_reg, pos_next;
    probe_t     cur_reg;
    logic       res_valid_reg, res_valid_next;
    out_item_t  res_reg, res_next;
    logic       adv;
    logic       load;

    function automatic logic [7:0] byte_at(input logic [5:0] p, input cfg_t c,
                                           input probe_t e);
        logic [7:0] b;
        b = 8'h00;
        case (p)
            6'd0:  b = c.dest_mac[47:40];
            6'd1:  b = c.dest_mac[39:32];
            6'd2:  b = c.dest_mac[31:24];
            6'd3:  b = c.dest_mac[23:16];
            6'd4:  b = c.dest_mac[15:8];
            6'd5:  b = c.dest_mac[7:0];
            6'd6:  b = c.source_mac[47:40];
            6'd7:  b = c.source_mac[39:32];
            6'd8:  b = c.source_mac[31:24];
            6'd9:  b = c.source_mac[23:16];
            6'd10: b = c.source_mac[15:8];
            6'd11: b = c.source_mac[7:0];
            6'd12: b = ETH_TYPE_IPV4[15:8];
            6'd13: b = ETH_TYPE_IPV4[7:0];
            6'd14: b = 8'h45;
            6'd16: b = IP_TOTAL_LEN[15:8];
            6'd17: b = IP_TOTAL_LEN[7:0];
            6'd18: b = e.ip_ident[15:8];
            6'd19: b = e.ip_ident[7:0];
            6'd20: b = 8'h40;               // don't fragment
            6'd22: b = c.time_to_live;
            6'd23: b = IP_PROTO_TCP;
            6'd24: b = e.ip_csum[15:8];
            6'd25: b = e.ip_csum[7:0];
            6'd26: b = c.source_ip[31:24];
            6'd27: b = c.source_ip[23:16];
            6'd28: b = c.source_ip[15:8];
            6'd29: b = c.source_ip[7:0];
            6'd30: b = c.dest_ip[31:24];
            6'd31: b = c.dest_ip[23:16];
            6'd32: b = c.dest_ip[15:8];
            6'd33: b = c.dest_ip[7:0];
            6'd34: b = c.source_port[15:8];
            6'd35: b = c.source_port[7:0];
            6'd36: b = e.dest_port[15:8];
            6'd37: b = e.dest_port[7:0];
            6'd38: b = TCP_SEQ[31:24];
            6'd39: b = TCP_SEQ[23:16];
            6'd40: b = TCP_SEQ[15:8];
            6'd41: b = TCP_SEQ[7:0];
            6'd46: b = 8'h70;               // data offset 7 words
            6'd47: b = 8'h02;               // SYN
            6'd48: b = TCP_WINDOW[15:8];
            6'd49: b = TCP_WINDOW[7:0];
            6'd50: b = e.tcp_csum[15:8];
            6'd51: b = e.tcp_csum[7:0];
            // MSS 1460, two NOPs, SACK permitted
            6'd54: b = 8'h02;
            6'd55: b = 8'h04;
            6'd56: b = 8'h05;
            6'd57: b = 8'hB4;
            6'd58: b = 8'h01;
            6'd59: b = 8'h01;
            6'd60: b = 8'h04;
            6'd61: b = 8'h02;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    assign adv  = !res_valid_reg || !result_stall;
    // take the next probe on the same edge the last byte goes out
    assign load = head_valid && (!active_reg || (adv && pos_reg == LAST_POS));
    assign pop  = load;

    always_comb
    begin
        active_next    = active_reg;
        pos_next       = pos_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (adv)
        begin
            res_valid_next     = active_reg;
            res_next.frame_byte = byte_at(pos_reg, cfg, cur_reg);
            res_next.last_byte  = (pos_reg == LAST_POS);
            if (active_reg)
            begin
                if (pos_reg == LAST_POS)
                begin
                    active_next = 1'b0;
                    pos_next    = '0;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
        if (load)
        begin
            active_next = 1'b1;
            pos_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pos_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            pos_reg       <= pos_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (load)
        begin
            cur_reg <= head_entry;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== src/tcp_syn_frame_builder.sv =====
// TCP SYN frame builder: one 62-byte Ethernet/IPv4/TCP SYN frame per item, one byte a cycle
// unless result_stall holds the output. A queue of QUEUE_DEPTH checksummed probes lets the
// front end keep accepting while a frame drains.
// Reset clears all control state and loads register defaults; no clearing pass.
// Depends on tsfb_pkg, tsfb_front, tsfb_queue, tsfb_back.
module tcp_syn_frame_builder
    import tsfb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  in_item_t               item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output out_item_t              result
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cfg_t          cfg_reg;
    logic          q_push, q_pop, q_head_valid;
    probe_t        q_push_entry, q_head_entry;
    logic [CW-1:0] q_count, front_credit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_mac   <= '0;
            cfg_reg.dest_mac     <= '0;
            cfg_reg.source_ip    <= '0;
            cfg_reg.dest_ip      <= '0;
            cfg_reg.source_port  <= SOURCE_PORT_RST;
            cfg_reg.time_to_live <= TTL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SOURCE_MAC:   cfg_reg.source_mac   <= cfg_data;
                REG_DEST_MAC:     cfg_reg.dest_mac     <= cfg_data;
                REG_SOURCE_IP:    cfg_reg.source_ip    <= cfg_data[31:0];
                REG_DEST_IP:      cfg_reg.dest_ip      <= cfg_data[31:0];
                REG_SOURCE_PORT:  cfg_reg.source_port  <= cfg_data[15:0];
                REG_TIME_TO_LIVE: cfg_reg.time_to_live <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    tsfb_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .pop        (q_pop),
        .push       (q_push),
        .push_entry (q_push_entry),
        .credit     (front_credit)
    );

    tsfb_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry),
        .count      (q_count)
    );

    tsfb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head_valid   (q_head_valid),
        .head_entry   (q_head_entry),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head_valid)
        else $error("queue popped while empty");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_count < CW'(QUEUE_DEPTH)) || q_pop)
        else $error("queue pushed while full");

    a_credit_covers_queue: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= front_credit)
        else $error("queue holds more items than front end accounted for");

endmodule

// ===== bench/tb_tcp_syn_frame_builder.sv =====
// Testbench for tcp_syn_frame_builder: drives probes and register writes, predicts each
// 62-byte SYN frame (addresses, TTL, ports, both checksums) and checks every output byte.
// Depends on tsfb_pkg and the tcp_syn_frame_builder RTL.
module tb_tcp_syn_frame_builder;
    import tsfb_pkg::*;

    localparam int FRAME_LEN = 62;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 24;
    localparam int HOLD_OFF_CYCLES = 500;
    localparam int RANDOM_PER_PHASE = 55;

    // indexes past the last register; writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   item_valid;
    logic                   item_stall;
    in_item_t               item;
    logic                   result_valid;
    logic                   result_stall;
    out_item_t              result;

    cfg_t       shadow_regs;
    out_item_t  frame_bytes_due[$];
    idle_mode_t idle_mode = IDLE_NONE;
    int         hold_left = 0;
    int         errors = 0;
    int         bytes_checked = 0;
    int         cycles = 0;

    tcp_syn_frame_builder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tcp_syn_frame_builder verification failed");
            $finish;
        end
    end

    // one's-complement fold of a 32-bit word sum, then invert
    function automatic logic [15:0] finish_csum(input logic [31:0] acc);
        acc = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
        acc = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
        return ~acc[15:0];
    endfunction

    // Build the whole frame for one probe and queue its bytes in wire order.
    function automatic void predict_syn_frame(input logic [15:0] dport,
                                              input logic [15:0] ident);
        logic [7:0]  f[FRAME_LEN];
        logic [31:0] acc;
        logic [15:0] csum;
        out_item_t   b;
        for (int k = 0; k < FRAME_LEN; k++)
            f[k] = 8'h00;
        for (int k = 0; k < 6; k++)
        begin
            f[k]     = shadow_regs.dest_mac[8*(5-k) +: 8];
            f[6 + k] = shadow_regs.source_mac[8*(5-k) +: 8];
        end
        f[12] = 8'h08;
        f[13] = 8'h00;
        f[14] = 8'h45;
        f[17] = 8'd48;
        {f[18], f[19]} = ident;
        f[20] = 8'h40;
        f[22] = shadow_regs.time_to_live;
        f[23] = 8'h06;
        {f[26], f[27], f[28], f[29]} = shadow_regs.source_ip;
        {f[30], f[31], f[32], f[33]} = shadow_regs.dest_ip;
        acc = 32'd0;
        for (int k = 14; k < 34; k += 2)
            acc += {16'h0000, f[k], f[k+1]};
        csum = finish_csum(acc);
        {f[24], f[25]} = csum;

        {f[34], f[35]} = shadow_regs.source_port;
        {f[36], f[37]} = dport;
        {f[38], f[39], f[40], f[41]} = 32'hB747_4CCC;
        f[46] = 8'h70;
        f[47] = 8'h02;
        f[48] = 8'h40;
        {f[54], f[55], f[56], f[57]} = 32'h0204_05B4;
        {f[58], f[59], f[60], f[61]} = 32'h0101_0402;
        // pseudo-header: addresses, protocol, segment length 28
        acc = {16'h0000, shadow_regs.source_ip[31:16]} + {16'h0000, shadow_regs.source_ip[15:0]}
            + {16'h0000, shadow_regs.dest_ip[31:16]} + {16'h0000, shadow_regs.dest_ip[15:0]}
            + 32'h0006 + 32'd28;
        for (int k = 34; k < FRAME_LEN; k += 2)
            acc += {16'h0000, f[k], f[k+1]};
        csum = finish_csum(acc);
        {f[50], f[51]} = csum;

        for (int k = 0; k < FRAME_LEN; k++)
        begin
            b.frame_byte = f[k];
            b.last_byte  = (k == FRAME_LEN - 1);
            frame_bytes_due.push_back(b);
        end
    endfunction

    // receiver side: long hold-off when requested, otherwise random stalls by phase
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_stall = 1'b1;
            hold_left--;
        end
        else if (idle_mode == IDLE_RECEIVER)
            result_stall = ($urandom_range(99) < 82);
        else if (idle_mode == IDLE_BOTH)
            result_stall = ($urandom_range(99) < 30);
        else
            result_stall = 1'b0;
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (frame_bytes_due.size() == 0)
            begin
                $display("%0t: unexpected byte %02h last %0b", $time,
                         result.frame_byte, result.last_byte);
                errors++;
            end
            else
            begin
                want = frame_bytes_due.pop_front();
                if (result.frame_byte !== want.frame_byte)
                begin
                    $display("%0t: frame_byte at offset %0d expected %02h actual %02h",
                             $time, bytes_checked % FRAME_LEN, want.frame_byte,
                             result.frame_byte);
                    errors++;
                end
                if (result.last_byte !== want.last_byte)
                begin
                    $display("%0t: last_byte at offset %0d expected %0b actual %0b",
                             $time, bytes_checked % FRAME_LEN, want.last_byte,
                             result.last_byte);
                    errors++;
                end
            end
            bytes_checked++;
        end
    end

    task automatic send_probe(input logic [15:0] dport, input logic [15:0] ident);
        @(negedge clk);
        while ((idle_mode == IDLE_SENDER && $urandom_range(99) < 82)
               || (idle_mode == IDLE_BOTH && $urandom_range(99) < 30))
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid     = 1'b1;
        item.dest_port = dport;
        item.ip_ident  = ident;
        do
            @(posedge clk);
        while (!(item_valid && !item_stall));
        predict_syn_frame(dport, ident);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [47:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_SOURCE_MAC:   shadow_regs.source_mac   = data;
            REG_DEST_MAC:     shadow_regs.dest_mac     = data;
            REG_SOURCE_IP:    shadow_regs.source_ip    = data[31:0];
            REG_DEST_IP:      shadow_regs.dest_ip      = data[31:0];
            REG_SOURCE_PORT:  shadow_regs.source_port  = data[15:0];
            REG_TIME_TO_LIVE: shadow_regs.time_to_live = data[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // stop offering items and wait for every predicted byte, plus pipeline slack
    task automatic wait_idle();
        @(negedge clk);
        item_valid = 1'b0;
        while (frame_bytes_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_all_regs(input logic [47:0] mac_s, input logic [47:0] mac_d,
                                  input logic [47:0] ip_s, input logic [47:0] ip_d,
                                  input logic [47:0] port, input logic [47:0] ttl);
        write_reg(REG_SOURCE_MAC, mac_s);
        write_reg(REG_DEST_MAC, mac_d);
        write_reg(REG_SOURCE_IP, ip_s);
        write_reg(REG_DEST_IP, ip_d);
        write_reg(REG_SOURCE_PORT, port);
        write_reg(REG_TIME_TO_LIVE, ttl);
    endtask

    function automatic logic [15:0] pick_field();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    task automatic test_reset_defaults();
        idle_mode = IDLE_NONE;
        send_probe(16'h0000, 16'h0000);
        send_probe(16'hFFFF, 16'hFFFF);
        send_probe(16'h0050, 16'h1234);
        wait_idle();
    endtask

    // all-ones writes also check that bits above each register's width are dropped
    task automatic test_register_extremes();
        write_all_regs({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}},
                       {48{1'b1}}, {48{1'b1}});
        send_probe(16'h0000, 16'hFFFF);
        send_probe(16'hFFFF, 16'h0000);
        send_probe(16'h5555, 16'hAAAA);
        wait_idle();
        write_all_regs('0, '0, '0, '0, '0, '0);
        send_probe(16'hAAAA, 16'h5555);
        send_probe(16'hFFFF, 16'hFFFF);
        wait_idle();
        write_all_regs(48'h0211_2233_4455, 48'hA0B1_C2D3_E4F5, 48'h0000_C0A8_0001,
                       48'h0000_0A00_00FE, 48'd61000, 48'd64);
        // writes to unused indexes must leave every register alone
        write_reg(REG_SPARE_LO, {48{1'b1}});
        write_reg(REG_SPARE_HI, 48'h1234_5678_9ABC);
        send_probe(16'd443, 16'h0001);
        send_probe(16'd22, 16'h8000);
        wait_idle();
    endtask

    // receiver holds off while the sender keeps offering, filling the probe queue
    task automatic test_backpressure();
        idle_mode = IDLE_NONE;
        @(posedge clk);
        hold_left = HOLD_OFF_CYCLES;
        for (int n = 0; n < 12; n++)
            send_probe(pick_field(), pick_field());
        wait_idle();
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                1: write_all_regs({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}},
                                  {48{1'b1}}, {48{1'b1}});
                3: write_all_regs('0, '0, '0, '0, '0, '0);
                default: write_all_regs(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                                        48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                                        48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
            endcase
            @(posedge clk);
            case (p)
                0: idle_mode = IDLE_NONE;
                1: idle_mode = IDLE_SENDER;
                2: idle_mode = IDLE_RECEIVER;
                default: idle_mode = IDLE_BOTH;
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_probe(pick_field(), pick_field());
            wait_idle();
            @(posedge clk);
            idle_mode = IDLE_NONE;
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        shadow_regs  = '0;
        shadow_regs.source_port  = 16'd61000;
        shadow_regs.time_to_live = 8'd64;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();

        if (errors == 0)
            $display("tcp_syn_frame_builder verification clean");
        else
            $display("tcp_syn_frame_builder verification failed");
        $finish;
    end

endmodule
